[rtl/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probe hash table
// Table geometry, status codes and the request record passed front to back.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BITS  = 32;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int SUM_W       = 8 + $clog2(KEY_BYTES + 1);
    localparam int LAP_W       = $clog2(TABLE_SLOTS + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [63:0]           key;
        logic [VALUE_BITS-1:0] value;
        logic [SLOT_W-1:0]     home;
    } t_req;

endpackage

[rtl/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// Put and get requests on byte-string keys, one status result per request.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  request   i_valid/o_ready, i_kind, i_key, i_value   in
//  result    o_valid/i_ready, o_status, o_result_value out
//
// A request is registered into the front-end queue, then each probe takes a
// slot read state and then a compare state, the result register loading at
// the last compare. After reset the valid marks are cleared by a pass over
// all TABLE_SLOTS (1024) slots, during which requests queue but are not
// served. The front end holds up to two requests, so it keeps accepting
// while the back end walks or while a result waits to be taken.
module linear_probe_hash_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [63:0] i_key,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_value
);

    logic           req_valid, req_ready;
    lpht_pkg::t_req req;

    lpht_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_key, .i_value,
        .o_req_valid(req_valid), .i_req_ready(req_ready), .o_req(req)
    );

    // The back end holds off new requests itself during the clearing pass.
    lpht_back u_back (
        .i_clk, .i_rst_n, .i_req_valid(req_valid), .o_req_ready(req_ready),
        .i_req(req), .o_valid, .i_ready, .o_status, .o_result_value
    );

endmodule

[rtl/lpht_front.sv]
// ----------------------------------------------------------------------------
// lpht_front: request intake, key normalisation and home-slot hashing
// Registers each classified request into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lpht_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [63:0]        i_key,
    input  logic [31:0]        i_value,
    output logic               o_req_valid,
    input  logic               i_req_ready,
    output lpht_pkg::t_req     o_req
);

    lpht_pkg::t_req r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic [63:0]    n_key;
    logic [lpht_pkg::SUM_W-1:0] n_sum;
    logic           alive;
    logic           push, pop;
    lpht_pkg::t_req n_req;

    // Keep bytes up to the first zero byte, then sum them.
    always_comb begin
        alive = 1'b1;
        n_key = '0;
        n_sum = '0;
        for (int i = 0; i < lpht_pkg::KEY_BYTES; i++) begin
            if (i_key[8*i +: 8] == 8'd0) alive = 1'b0;
            if (alive) begin
                n_key[8*i +: 8] = i_key[8*i +: 8];
                n_sum = n_sum + lpht_pkg::SUM_W'(i_key[8*i +: 8]);
            end
        end
        n_req.kind  = i_kind;
        n_req.key   = n_key;
        n_req.value = lpht_pkg::VALUE_BITS'(i_value);
        n_req.home  = lpht_pkg::SLOT_W'(n_sum % lpht_pkg::TABLE_SLOTS);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_req;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/lpht_back.sv]
// ----------------------------------------------------------------------------
// lpht_back: probe walk over the slot memories
// Each probe is a memory read state, then a compare state that steps or finishes.
// ----------------------------------------------------------------------------
module lpht_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  lpht_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [31:0]    o_result_value
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    localparam int SW = lpht_pkg::SLOT_W;
    localparam int VW = lpht_pkg::VALUE_BITS;

    logic          r_vld_mem [lpht_pkg::TABLE_SLOTS];
    logic [63:0]   r_key_mem [lpht_pkg::TABLE_SLOTS];
    logic [VW-1:0] r_val_mem [lpht_pkg::TABLE_SLOTS];

    t_state         r_state;
    lpht_pkg::t_req r_req;
    logic [SW-1:0]  r_idx;
    logic [lpht_pkg::LAP_W-1:0] r_lap;
    logic           r_rd_vld;
    logic [63:0]    r_rd_key;
    logic [VW-1:0]  r_rd_val;
    logic           r_out_valid;
    logic [1:0]     r_status;
    logic [31:0]    r_rvalue;
    logic           stop, last;
    logic [SW-1:0]  n_idx;

    assign stop  = !r_rd_vld || (r_rd_key == r_req.key);
    assign last  = (r_lap == lpht_pkg::LAP_W'(lpht_pkg::TABLE_SLOTS - 1));
    assign n_idx = (r_idx == SW'(lpht_pkg::TABLE_SLOTS - 1)) ? '0 : r_idx + 1'b1;

    assign o_req_ready    = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = r_rvalue;

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld_mem[r_idx];
        r_rd_key <= r_key_mem[r_idx];
        r_rd_val <= r_val_mem[r_idx];
        if (r_state == S_CLEAR) r_vld_mem[r_idx] <= 1'b0;
        if (r_state == S_CHECK && stop && r_req.kind == lpht_pkg::KIND_PUT) begin
            r_vld_mem[r_idx] <= 1'b1;
            r_key_mem[r_idx] <= r_req.key;
            r_val_mem[r_idx] <= r_req.value;
        end
        if (r_state == S_IDLE && o_req_ready && i_req_valid) r_req <= i_req;
        if (r_state == S_CHECK) begin
            if (stop) begin
                if (r_req.kind == lpht_pkg::KIND_PUT) begin
                    r_status <= lpht_pkg::ST_OK;
                    r_rvalue <= '0;
                end else if (r_rd_vld) begin
                    r_status <= lpht_pkg::ST_OK;
                    r_rvalue <= 32'(r_rd_val);
                end else begin
                    r_status <= lpht_pkg::ST_MISS;
                    r_rvalue <= '0;
                end
            end else begin
                r_status <= (r_req.kind == lpht_pkg::KIND_PUT) ?
                            lpht_pkg::ST_FULL : lpht_pkg::ST_MISS;
                r_rvalue <= '0;
            end
        end
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_lap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_idx <= n_idx;
                    if (r_idx == SW'(lpht_pkg::TABLE_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_req_ready && i_req_valid) begin
                        r_idx   <= i_req.home;
                        r_lap   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (stop || last) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_idx   <= n_idx;
                        r_lap   <= r_lap + 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/lpht_checker.sv]
// ----------------------------------------------------------------------------
// lpht_checker: port-level checks for the hash table
// Watches results for legal codes, zero values on miss or full, and stable presentation.
// ----------------------------------------------------------------------------
module lpht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_result_value
);

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == lpht_pkg::ST_OK || o_status == lpht_pkg::ST_MISS
                     || o_status == lpht_pkg::ST_FULL))
        else $error("illegal status");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != lpht_pkg::ST_OK) |-> (o_result_value == 32'd0))
        else $error("non-zero value on miss or full");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
                                   && $stable(o_result_value)))
        else $error("result dropped while stalled");

endmodule

bind linear_probe_hash_table lpht_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_status, .o_result_value
);
